@@ rtl/dtp_pkg.sv @@
package dtp_pkg;

   localparam int COORD_BITS = 12;
   localparam int DISP_W = 16;
   localparam int LIMIT_W = 17;
   localparam int SCALE_W = 25;
   localparam int REG_W = 32;
   localparam int CSR_IDX_W = 3;
   localparam int PROD_W = REG_W + SCALE_W;
   localparam int DEN_PROD_W = REG_W + DISP_W;
   localparam int DEN_W = DEN_PROD_W - 1;
   localparam int FRAC = 16;
   localparam int AXY_W = 41;
   localparam int XY_SHIFT = 24;
   localparam int Z_SHIFT = 8;
   localparam int NUM_W = AXY_W + XY_SHIFT;
   localparam int Q_W = 32;
   localparam int DIV_STEPS = Q_W;
   localparam int FRONT = 4;
   localparam int STAGES = FRONT + DIV_STEPS + 1;

   localparam logic [SCALE_W-1:0] SCALE_RESET = SCALE_W'(65536);
   localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(32768);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_PRINCIPAL_X    = 3'd0,
      CSR_PRINCIPAL_Y    = 3'd1,
      CSR_FOCAL_LENGTH   = 3'd2,
      CSR_INV_BASELINE   = 3'd3,
      CSR_IMAGE_SCALE    = 3'd4,
      CSR_DISPARITY_LIMIT = 3'd5
   } csr_index_type;

   typedef struct packed {
      logic [DEN_W-1:0] p;
      logic [Q_W-1:0]   lo;
      logic [Q_W-1:0]   q;
      logic             cap;
      logic             neg;
   } div_lane_type;

   typedef struct packed {
      div_lane_type     x;
      div_lane_type     y;
      div_lane_type     z;
      logic [DEN_W-1:0] den;
      logic             ok;
   } div_stage_type;

   function automatic div_lane_type div_init(logic [NUM_W-1:0] n, logic [DEN_W-1:0] d,
                                             logic neg);
      div_lane_type r;
      logic [DEN_W-1:0] hi;
      hi = {{(DEN_W-(NUM_W-Q_W)){1'b0}}, n[NUM_W-1:Q_W]};
      r.cap = (hi >= d);
      r.p = r.cap ? '0 : hi;
      r.lo = n[Q_W-1:0];
      r.q = '0;
      r.neg = neg;
      return r;
   endfunction

   function automatic div_lane_type div_step(div_lane_type a, logic [DEN_W-1:0] d);
      div_lane_type r;
      logic [DEN_W:0] t;
      r = a;
      t = {a.p, a.lo[Q_W-1]};
      r.lo = {a.lo[Q_W-2:0], 1'b0};
      if (t >= {1'b0, d}) begin
         t = t - {1'b0, d};
         r.q = {a.q[Q_W-2:0], 1'b1};
      end else begin
         r.q = {a.q[Q_W-2:0], 1'b0};
      end
      r.p = t[DEN_W-1:0];
      return r;
   endfunction

   function automatic logic [Q_W-1:0] div_result(div_lane_type a);
      logic [Q_W-1:0] m;
      logic [Q_W-1:0] r;
      m = (a.cap || a.q[Q_W-1]) ? {1'b1, {(Q_W-1){1'b0}}} : a.q;
      if (a.neg) begin
         r = '0 - m;
      end else begin
         r = m[Q_W-1] ? {1'b0, {(Q_W-1){1'b1}}} : m;
      end
      return r;
   endfunction

endpackage

@@ rtl/dtp_req_if.sv @@
interface dtp_req_if import dtp_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [COORD_BITS-1:0] pixel_row;
   logic [COORD_BITS-1:0] pixel_col;
   logic [DISP_W-1:0]     disparity;

   modport source (output valid, pixel_row, pixel_col, disparity, input ready);
   modport sink (input valid, pixel_row, pixel_col, disparity, output ready);
endinterface

@@ rtl/dtp_rsp_if.sv @@
interface dtp_rsp_if import dtp_pkg::*; ();
   logic             valid;
   logic             ready;
   logic             point_valid;
   logic [Q_W-1:0]   point_x;
   logic [Q_W-1:0]   point_y;
   logic [Q_W-1:0]   point_z;

   modport source (output valid, point_valid, point_x, point_y, point_z, input ready);
   modport sink (input valid, point_valid, point_x, point_y, point_z, output ready);
endinterface

@@ rtl/dtp_csr_if.sv @@
interface dtp_csr_if import dtp_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   logic [REG_W-1:0]     data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

@@ rtl/disparity_to_point_reprojection.sv @@
// path: stages a, b and c, divider load, divider steps, then the output register
// throughput: one transaction per cycle unless stalled, set by a 32-stage restoring
// divider with one quotient bit per stage and one lane each for x, y and z
// stalls collapse bubbles stage by stage; nothing is dropped or repeated
// reset: synchronous, clears all stage valid bits and loads register defaults
module disparity_to_point_reprojection import dtp_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   dtp_req_if.sink   req_chan,
   dtp_rsp_if.source rsp_chan,
   dtp_csr_if.sink   csr_chan
);

   logic [REG_W-1:0]   principal_x_ff;
   logic [REG_W-1:0]   principal_y_ff;
   logic [REG_W-1:0]   focal_length_ff;
   logic [REG_W-1:0]   inv_baseline_ff;
   logic [SCALE_W-1:0] image_scale_ff;
   logic [LIMIT_W-1:0] disparity_limit_ff;

   logic [STAGES-1:0] vld_ff;
   logic [STAGES-1:0] adv;

   // stage a
   logic [COORD_BITS-1:0] a_row_ff, a_col_ff;
   logic [DISP_W-1:0]     a_v_ff;
   logic                  a_ok_ff;
   logic [DISP_W-1:0]     a_v_in;
   logic                  a_ok_in;

   // stage b
   logic [COORD_BITS-1:0]        b_row_ff, b_col_ff;
   logic signed [PROD_W-1:0]     b_pxs_ff, b_pys_ff, b_fzs_ff;
   logic signed [DEN_PROD_W-1:0] b_den_ff;
   logic                         b_ok_ff;

   // stage c
   logic [AXY_W-1:0]  c_ay_mag_ff, c_ax_mag_ff;
   logic [PROD_W-1:0] c_fz_mag_ff;
   logic [DEN_W-1:0]  c_den_ff;
   logic              c_ay_neg_ff, c_ax_neg_ff, c_fz_neg_ff, c_ok_ff;
   logic signed [AXY_W-1:0] ay, ax;
   logic              den_neg;

   // divider
   div_stage_type d_init_in;
   div_stage_type div_ff [DIV_STEPS+1];

   // output
   logic           o_valid_ff;
   logic [Q_W-1:0] o_x_ff, o_y_ff, o_z_ff;

   assign csr_chan.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         principal_x_ff <= '0;
         principal_y_ff <= '0;
         focal_length_ff <= '0;
         inv_baseline_ff <= '0;
         image_scale_ff <= SCALE_RESET;
         disparity_limit_ff <= LIMIT_RESET;
      end else if (csr_chan.valid) begin
         case (csr_chan.index)
            CSR_PRINCIPAL_X: principal_x_ff <= csr_chan.data;
            CSR_PRINCIPAL_Y: principal_y_ff <= csr_chan.data;
            CSR_FOCAL_LENGTH: focal_length_ff <= csr_chan.data;
            CSR_INV_BASELINE: inv_baseline_ff <= csr_chan.data;
            CSR_IMAGE_SCALE: image_scale_ff <= csr_chan.data[SCALE_W-1:0];
            CSR_DISPARITY_LIMIT: disparity_limit_ff <= csr_chan.data[LIMIT_W-1:0];
            default: ;
         endcase
      end
   end

   // bubble-collapsing advance chain
   always_comb begin
      adv[STAGES-1] = !vld_ff[STAGES-1] || rsp_chan.ready;
      for (int i = STAGES-2; i >= 0; i--) begin
         adv[i] = !vld_ff[i] || adv[i+1];
      end
   end

   assign req_chan.ready = adv[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         if (adv[0]) vld_ff[0] <= req_chan.valid;
         for (int i = 1; i < STAGES; i++) begin
            if (adv[i]) vld_ff[i] <= vld_ff[i-1];
         end
      end
   end

   assign a_v_in = '0 - req_chan.disparity;
   assign a_ok_in = a_v_in[DISP_W-1]
      && ($signed({a_v_in[DISP_W-1], a_v_in}) < $signed(disparity_limit_ff));

   always_ff @(posedge clock) begin
      if (adv[0]) begin
         a_row_ff <= req_chan.pixel_row;
         a_col_ff <= req_chan.pixel_col;
         a_v_ff <= a_v_in;
         a_ok_ff <= a_ok_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv[1]) begin
         b_row_ff <= a_row_ff;
         b_col_ff <= a_col_ff;
         b_pxs_ff <= $signed(principal_x_ff) * $signed({1'b0, image_scale_ff});
         b_pys_ff <= $signed(principal_y_ff) * $signed({1'b0, image_scale_ff});
         b_fzs_ff <= $signed(focal_length_ff) * $signed({1'b0, image_scale_ff});
         b_den_ff <= $signed(inv_baseline_ff) * $signed(a_v_ff);
         b_ok_ff <= a_ok_ff;
      end
   end

   assign ay = $signed({{(AXY_W-COORD_BITS-FRAC){1'b0}}, b_col_ff, {FRAC{1'b0}}})
      + $signed(b_pxs_ff[PROD_W-1:FRAC]);
   assign ax = $signed({{(AXY_W-COORD_BITS-FRAC){1'b0}}, b_row_ff, {FRAC{1'b0}}})
      + $signed(b_pys_ff[PROD_W-1:FRAC]);
   assign den_neg = b_den_ff[DEN_PROD_W-1];

   always_ff @(posedge clock) begin
      if (adv[2]) begin
         c_ay_mag_ff <= ay[AXY_W-1] ? AXY_W'(-ay) : AXY_W'(ay);
         c_ax_mag_ff <= ax[AXY_W-1] ? AXY_W'(-ax) : AXY_W'(ax);
         c_fz_mag_ff <= b_fzs_ff[PROD_W-1] ? PROD_W'(-b_fzs_ff) : PROD_W'(b_fzs_ff);
         c_den_ff <= den_neg ? DEN_W'(-b_den_ff) : DEN_W'(b_den_ff);
         c_ay_neg_ff <= ay[AXY_W-1] ^ den_neg;
         c_ax_neg_ff <= ax[AXY_W-1] ^ den_neg;
         c_fz_neg_ff <= b_fzs_ff[PROD_W-1] ^ den_neg;
         c_ok_ff <= b_ok_ff && (b_den_ff != '0);
      end
   end

   always_comb begin
      d_init_in.x = div_init({c_ay_mag_ff, {XY_SHIFT{1'b0}}}, c_den_ff, c_ay_neg_ff);
      d_init_in.y = div_init({c_ax_mag_ff, {XY_SHIFT{1'b0}}}, c_den_ff, c_ax_neg_ff);
      d_init_in.z = div_init({c_fz_mag_ff, {Z_SHIFT{1'b0}}}, c_den_ff, c_fz_neg_ff);
      d_init_in.den = c_den_ff;
      d_init_in.ok = c_ok_ff;
   end

   always_ff @(posedge clock) begin
      if (adv[FRONT-1]) div_ff[0] <= d_init_in;
      for (int j = 1; j <= DIV_STEPS; j++) begin
         if (adv[FRONT-1+j]) begin
            div_ff[j].x <= div_step(div_ff[j-1].x, div_ff[j-1].den);
            div_ff[j].y <= div_step(div_ff[j-1].y, div_ff[j-1].den);
            div_ff[j].z <= div_step(div_ff[j-1].z, div_ff[j-1].den);
            div_ff[j].den <= div_ff[j-1].den;
            div_ff[j].ok <= div_ff[j-1].ok;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv[STAGES-1]) begin
         o_valid_ff <= div_ff[DIV_STEPS].ok;
         o_x_ff <= div_ff[DIV_STEPS].ok ? div_result(div_ff[DIV_STEPS].x) : '0;
         o_y_ff <= div_ff[DIV_STEPS].ok ? div_result(div_ff[DIV_STEPS].y) : '0;
         o_z_ff <= div_ff[DIV_STEPS].ok ? div_result(div_ff[DIV_STEPS].z) : '0;
      end
   end

   assign rsp_chan.valid = vld_ff[STAGES-1];
   assign rsp_chan.point_valid = o_valid_ff;
   assign rsp_chan.point_x = o_x_ff;
   assign rsp_chan.point_y = o_y_ff;
   assign rsp_chan.point_z = o_z_ff;

endmodule

@@ rtl/dtp_checker.sv @@
module dtp_checker import dtp_pkg::*; (
   input logic           clock,
   input logic           reset,
   input logic           req_ready,
   input logic           rsp_valid,
   input logic           rsp_ready,
   input logic           rsp_point_valid,
   input logic [Q_W-1:0] rsp_point_x,
   input logic [Q_W-1:0] rsp_point_y,
   input logic [Q_W-1:0] rsp_point_z
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");

   a_invalid_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_point_valid |->
         rsp_point_x == '0 && rsp_point_y == '0 && rsp_point_z == '0)
      else $error("rejected point carries nonzero coordinates");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("request stalled with empty output");

endmodule

bind disparity_to_point_reprojection dtp_checker u_dtp_checker (
   .clock(clock),
   .reset(reset),
   .req_ready(req_chan.ready),
   .rsp_valid(rsp_chan.valid),
   .rsp_ready(rsp_chan.ready),
   .rsp_point_valid(rsp_chan.point_valid),
   .rsp_point_x(rsp_chan.point_x),
   .rsp_point_y(rsp_chan.point_y),
   .rsp_point_z(rsp_chan.point_z)
);
